/* rtl/core/bchd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and constants for the button click and hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

  // Field widths
  localparam int NUM_BUTTONS_DEF = 5;
  localparam int NUM_LEVELS      = 5;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int BTN_W           = 3;
  localparam int CLICK_W         = 4;
  localparam int SECS_W          = 6;

  // Saturation limits
  localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;
  localparam logic [SECS_W-1:0]  SECS_MAX  = 6'd63;

  // ms to seconds: q = (d * RECIP_MULT) >> RECIP_SHIFT, exact for 16-bit d
  localparam int MS_PER_SEC  = 1000;
  localparam int DUR_W       = 16;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC);
  localparam int PROD_W      = DUR_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IGNORE      = 3'd0,
    REG_MULTI_CLICK = 3'd1,
    REG_HOLD_MIN    = 3'd2,
    REG_HOLD_REPEAT = 3'd3,
    REG_HOLD_MAX    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] ignore_ms;
    logic [CFG_W-1:0] multi_click_ms;
    logic [CFG_W-1:0] hold_min_ms;
    logic [CFG_W-1:0] hold_repeat_ms;
    logic [CFG_W-1:0] hold_max_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ignore_ms:      16'd50,
    multi_click_ms: 16'd250,
    hold_min_ms:    16'd1000,
    hold_repeat_ms: 16'd1000,
    hold_max_ms:    16'd50500
  };

  // What one lane found for one sample
  typedef struct packed {
    logic               edge_seen;
    logic               edge_is_release;
    logic               clicks_ready;
    logic [CLICK_W-1:0] clicks;
    logic               hold_seen;
    logic [SECS_W-1:0]  hold_seconds;
  } lane_res_t;

endpackage
`default_nettype wire

/* rtl/core/bchd_sample_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_sample_if
// Input channel: one beat is one sample of button levels with a time stamp.
// ----------------------------------------------------------------------------
interface bchd_sample_if import bchd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NUM_LEVELS-1:0] levels;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, levels, now_ms, input ready);
  modport sink   (input valid, levels, now_ms, output ready);
endinterface
`default_nettype wire

/* rtl/core/bchd_report_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_report_if
// Output channel: one beat is one lane report for a sample.
// ----------------------------------------------------------------------------
interface bchd_report_if import bchd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BTN_W-1:0]   button;
  logic               edge_seen;
  logic               edge_is_release;
  logic               clicks_ready;
  logic [CLICK_W-1:0] clicks;
  logic               hold_seen;
  logic [SECS_W-1:0]  hold_seconds;
  logic               last;

  modport source (output valid, button, edge_seen, edge_is_release, clicks_ready,
                  clicks, hold_seen, hold_seconds, last, input ready);
  modport sink   (input valid, button, edge_seen, edge_is_release, clicks_ready,
                  clicks, hold_seen, hold_seconds, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/bchd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_lane
// Per-button tracker: press/release edges, click counting, hold repeats.
// State advances on every accepted sample.
// ----------------------------------------------------------------------------
module bchd_lane import bchd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              pushed,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire cfg_t              cfg,
  output lane_res_t              res,
  output logic                   hit
);

  // Lane state
  logic               is_down, release_valid, press_valid, hold_valid;
  logic [CLICK_W-1:0] click_total;
  logic [TIME_W-1:0]  release_time, press_time, hold_time;

  logic               is_down_next, release_valid_next, press_valid_next;
  logic               hold_valid_next;
  logic [CLICK_W-1:0] click_total_next;

  logic              press_ok, release_ok, quiet_ok, hold_ok;
  logic [TIME_W-1:0] since_rel, held, since_hold;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  always_comb begin
    since_rel  = now_ms - release_time;
    held       = now_ms - press_time;
    since_hold = now_ms - hold_time;
    prod       = PROD_W'(held[DUR_W-1:0]) * PROD_W'(RECIP_MULT);
    quot       = prod[PROD_W-1:RECIP_SHIFT];

    // press: not within the ignore window of the last release
    press_ok = pushed && !is_down &&
               !(release_valid && (since_rel < TIME_W'(cfg.ignore_ms)));
    // release
    release_ok = !pushed && is_down;
    // quiet long enough after release; a fresh release has zero distance,
    // and a fresh press puts the button down again
    quiet_ok = release_valid && !is_down && !release_ok && !press_ok &&
               (since_rel > TIME_W'(cfg.multi_click_ms));
    // hold; a fresh press has zero duration and never holds
    hold_ok = pushed && is_down && press_valid &&
              (held > TIME_W'(cfg.hold_min_ms)) &&
              (held < TIME_W'(cfg.hold_max_ms)) &&
              (!hold_valid || (since_hold > TIME_W'(cfg.hold_repeat_ms)));

    is_down_next       = is_down;
    release_valid_next = release_valid;
    press_valid_next   = press_valid;
    hold_valid_next    = hold_valid;
    click_total_next   = click_total;

    if (press_ok) begin
      is_down_next     = 1'b1;
      press_valid_next = 1'b1;
    end
    if (release_ok) begin
      is_down_next       = 1'b0;
      release_valid_next = 1'b1;
      if (click_total < CLICK_MAX) begin
        click_total_next = click_total + 1'b1;
      end
    end
    if (quiet_ok) begin
      release_valid_next = 1'b0;
      hold_valid_next    = 1'b0;
      click_total_next   = '0;
    end
    if (hold_ok) begin
      hold_valid_next = 1'b1;
    end

    res.edge_seen       = press_ok || release_ok;
    res.edge_is_release = release_ok;
    res.clicks_ready    = quiet_ok && !hold_valid;
    res.clicks          = (quiet_ok && !hold_valid) ? click_total : '0;
    res.hold_seen       = hold_ok;
    if (!hold_ok) begin
      res.hold_seconds = '0;
    end else if (quot > QUOT_W'(SECS_MAX)) begin
      res.hold_seconds = SECS_MAX;
    end else begin
      res.hold_seconds = quot[SECS_W-1:0];
    end
    hit = press_ok || release_ok || (quiet_ok && !hold_valid) || hold_ok;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      is_down       <= 1'b0;
      release_valid <= 1'b0;
      press_valid   <= 1'b0;
      hold_valid    <= 1'b0;
      click_total   <= '0;
    end else if (step) begin
      is_down       <= is_down_next;
      release_valid <= release_valid_next;
      press_valid   <= press_valid_next;
      hold_valid    <= hold_valid_next;
      click_total   <= click_total_next;
    end
  end

  // Time stamps, only read under their valid flags
  always_ff @(posedge clk) begin
    if (step && press_ok) begin
      press_time <= now_ms;
    end
    if (step && release_ok) begin
      release_time <= now_ms;
    end
    if (step && hold_ok) begin
      hold_time <= now_ms;
    end
  end

  // A button counted as down always has a press time
  a_down_has_press: assert property (@(posedge clk) disable iff (rst)
    is_down |-> press_valid)
    else $error("lane down without press time");

  // A release always leaves a pending click sequence
  a_release_arms: assert property (@(posedge clk) disable iff (rst)
    (step && release_ok) |=> (release_valid && click_total != '0))
    else $error("release did not arm click sequence");

  // A hold report marks the hold time valid
  a_hold_marks: assert property (@(posedge clk) disable iff (rst)
    (step && hold_ok) |=> hold_valid)
    else $error("hold event not recorded");

endmodule
`default_nettype wire

/* rtl/core/bchd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_merge
// Captures the lane findings of one sample and sends them out in lane order,
// one beat per cycle unless the output stalls, flagging the final beat.
// ----------------------------------------------------------------------------
module bchd_merge import bchd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire lane_res_t              lane_res [NUM_BUTTONS],
  input  wire logic [NUM_BUTTONS-1:0] lane_hit,
  output logic                        in_ready,
  bchd_report_if.source               report
);

  localparam int LANE_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  lane_res_t              pend [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] pend_mask;
  logic [NUM_BUTTONS-1:0] pick_bit, mask_after;
  logic [LANE_W-1:0]      sel;
  logic                   out_free, pick;

  // Lowest pending lane goes out first
  always_comb begin
    sel = '0;
    for (int k = NUM_BUTTONS - 1; k >= 0; k--) begin
      if (pend_mask[k]) begin
        sel = LANE_W'(k);
      end
    end
    pick_bit   = pend_mask & (~pend_mask + 1'b1);
    out_free   = !report.valid || report.ready;
    pick       = (pend_mask != '0) && out_free;
    mask_after = pick ? (pend_mask & ~pick_bit) : pend_mask;
    in_ready   = (mask_after == '0);
  end

  // Pending findings
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (load) begin
      pend_mask <= lane_hit;
    end else begin
      pend_mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend <= lane_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (out_free) begin
      report.valid <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      report.button          <= BTN_W'(32'(sel) + 1);
      report.edge_seen       <= pend[sel].edge_seen;
      report.edge_is_release <= pend[sel].edge_is_release;
      report.clicks_ready    <= pend[sel].clicks_ready;
      report.clicks          <= pend[sel].clicks;
      report.hold_seen       <= pend[sel].hold_seen;
      report.hold_seconds    <= pend[sel].hold_seconds;
      report.last            <= (mask_after == '0);
    end
  end

  // Pending work with a free output always produces a beat
  a_pick_fills: assert property (@(posedge clk) disable iff (rst)
    ((pend_mask != '0) && out_free) |=> report.valid)
    else $error("pending report not sent");

  // Final beat of a sample carries last, others do not
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    pick |=> (report.last == $past(mask_after == '0)))
    else $error("last flag wrong");

  // Without a new sample the pending set only shrinks
  a_mask_shrinks: assert property (@(posedge clk) disable iff (rst)
    !load |=> ($countones(pend_mask) <= $countones($past(pend_mask))))
    else $error("pending set grew without a sample");

endmodule
`default_nettype wire

/* rtl/core/button_click_hold_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Multi-click and long-press detection for a bank of push buttons, one lane
// per button, with lane reports merged onto one output channel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  sample    in   levels[4:0], now_ms[31:0]
//  report    out  button, edge_seen, edge_is_release, clicks_ready, clicks,
//                 hold_seen, hold_seconds, last
//  cfg_*     in   write enable, register index, 16-bit data
//
// All lanes update at once on each accepted sample. Its reports leave one per
// cycle while the output is not stalled; a sample has 1 to NUM_BUTTONS
// reports, and a quiet sample has none and does not hold up the next one.
// The next sample is taken in the cycle the last report of the previous one
// moves to the output register. Output stalls hold the pending reports.
// Synchronous reset clears lane state and loads register defaults.
// ----------------------------------------------------------------------------
module button_click_hold_detector import bchd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bchd_sample_if.sink               sample,
  bchd_report_if.source             report
);

  cfg_t                   cfg;
  logic                   step;
  logic                   merge_ready;
  lane_res_t              lane_res [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] lane_hit;

  assign sample.ready = merge_ready;
  assign step         = sample.valid && merge_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IGNORE:      cfg.ignore_ms      <= cfg_data;
        REG_MULTI_CLICK: cfg.multi_click_ms <= cfg_data;
        REG_HOLD_MIN:    cfg.hold_min_ms    <= cfg_data;
        REG_HOLD_REPEAT: cfg.hold_repeat_ms <= cfg_data;
        REG_HOLD_MAX:    cfg.hold_max_ms    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // One lane per button; lanes past the level bits see the button up
  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_lane
    logic pushed;
    if (k < NUM_LEVELS) begin : g_lvl
      assign pushed = sample.levels[k];
    end else begin : g_up
      assign pushed = 1'b0;
    end

    bchd_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .step   (step),
      .pushed (pushed),
      .now_ms (sample.now_ms),
      .cfg    (cfg),
      .res    (lane_res[k]),
      .hit    (lane_hit[k])
    );
  end

  bchd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .lane_res (lane_res),
    .lane_hit (lane_hit),
    .in_ready (merge_ready),
    .report   (report)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button click and hold detector. A short
// directed table covers press, release, ignored press, click report, hold
// repeat, seconds saturation and time wrap. Random phases follow, each under
// its own register setting, built from click trains, long presses and noise.
// Every sample beat runs through a lane-by-lane event model; report beats are
// compared field by field, in order, against it or a typed row's report.
// ----------------------------------------------------------------------------
module tb_top;
  import bchd_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int LANES          = NUM_BUTTONS_DEF;
  localparam int DRAIN_CYCLES   = 8;
  localparam int END_CYCLES     = 20;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 26;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    lane_res_t        res;
    logic             last;
  } report_t;

  typedef struct packed {
    logic                  load_cfg;
    cfg_t                  cfg;
    logic [NUM_LEVELS-1:0] levels;
    logic [TIME_W-1:0]     now_ms;
    logic                  typed;
    report_t               want;
  } step_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bchd_sample_if smp ();
  bchd_report_if rpt ();

  button_click_hold_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .report    (rpt)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Lane model state and register copy
  cfg_t              model_cfg;
  logic              lane_down [LANES];
  logic [TIME_W-1:0] rel_at    [LANES];
  logic              rel_ok    [LANES];
  logic [TIME_W-1:0] press_at  [LANES];
  logic              press_ok  [LANES];
  logic [TIME_W-1:0] hold_at   [LANES];
  logic              hold_ok   [LANES];
  logic [CLICK_W-1:0] click_cnt [LANES];

  report_t   sample_hits[$];
  report_t   pending_reports[$];
  step_row_t directed_steps[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  phase_items;
  bit  hold_off_req = 1'b0;
  logic [TIME_W-1:0]     now_t;
  logic [NUM_LEVELS-1:0] cur_lv;

  function automatic void clear_lanes();
    model_cfg = CFG_RESET;
    for (int k = 0; k < LANES; k++) begin
      lane_down[k] = 1'b0;
      rel_at[k]    = '0;
      rel_ok[k]    = 1'b0;
      press_at[k]  = '0;
      press_ok[k]  = 1'b0;
      hold_at[k]   = '0;
      hold_ok[k]   = 1'b0;
      click_cnt[k] = '0;
    end
  endfunction

  // Append one row to the directed table
  function automatic void add_row(step_row_t s);
    directed_steps = {directed_steps, s};
  endfunction

  // Work out the lane reports one sample causes, in lane order
  function automatic void detect_events(input logic [NUM_LEVELS-1:0] lv,
                                        input logic [TIME_W-1:0] t);
    logic pushed, ev, rel, rdy, hold, spaced;
    logic [CLICK_W-1:0] n_clicks;
    logic [TIME_W-1:0] held, secs;
    report_t r;
    sample_hits.delete();
    for (int k = 0; k < LANES; k++) begin
      pushed   = lv[k];
      ev       = 1'b0;
      rel      = 1'b0;
      rdy      = 1'b0;
      hold     = 1'b0;
      n_clicks = '0;
      secs     = '0;
      // press, unless too soon after the last release
      if (pushed && !lane_down[k] &&
          !(rel_ok[k] && (t - rel_at[k]) < TIME_W'(model_cfg.ignore_ms))) begin
        ev          = 1'b1;
        lane_down[k] = 1'b1;
        press_at[k] = t;
        press_ok[k] = 1'b1;
      end
      // release counts a click
      if (!pushed && lane_down[k]) begin
        ev  = 1'b1;
        rel = 1'b1;
        if (click_cnt[k] != CLICK_MAX) click_cnt[k] = click_cnt[k] + 1'b1;
        rel_at[k]    = t;
        rel_ok[k]    = 1'b1;
        lane_down[k] = 1'b0;
      end
      // quiet long enough: report the count unless a hold came, then clear
      if (rel_ok[k] && !lane_down[k] &&
          (t - rel_at[k]) > TIME_W'(model_cfg.multi_click_ms)) begin
        if (!hold_ok[k]) begin
          rdy      = 1'b1;
          n_clicks = click_cnt[k];
        end
        rel_ok[k]    = 1'b0;
        rel_at[k]    = '0;
        hold_ok[k]   = 1'b0;
        hold_at[k]   = '0;
        click_cnt[k] = '0;
      end
      // hold repeat while down
      if (pushed && lane_down[k] && press_ok[k]) begin
        held   = t - press_at[k];
        spaced = !hold_ok[k] || (t - hold_at[k]) > TIME_W'(model_cfg.hold_repeat_ms);
        if (held > TIME_W'(model_cfg.hold_min_ms) && spaced &&
            held < TIME_W'(model_cfg.hold_max_ms)) begin
          hold = 1'b1;
          secs = held / MS_PER_SEC;
          if (secs > TIME_W'(SECS_MAX)) secs = TIME_W'(SECS_MAX);
          hold_at[k] = t;
          hold_ok[k] = 1'b1;
        end
      end
      if (ev || rdy || hold) begin
        r.button              = BTN_W'(k + 1);
        r.res.edge_seen       = ev;
        r.res.edge_is_release = rel;
        r.res.clicks_ready    = rdy;
        r.res.clicks          = n_clicks;
        r.res.hold_seen       = hold;
        r.res.hold_seconds    = SECS_W'(secs);
        r.last                = 1'b0;
        sample_hits = {sample_hits, r};
      end
    end
    if (sample_hits.size() > 0) sample_hits[sample_hits.size() - 1].last = 1'b1;
  endfunction

  // Single-report expectation for the directed table
  function automatic report_t lone_report(int btn, bit ev, bit rel, bit rdy,
                                          int clicks, bit hold, int secs);
    report_t r;
    r.button              = BTN_W'(btn);
    r.res.edge_seen       = ev;
    r.res.edge_is_release = rel;
    r.res.clicks_ready    = rdy;
    r.res.clicks          = CLICK_W'(clicks);
    r.res.hold_seen       = hold;
    r.res.hold_seconds    = SECS_W'(secs);
    r.last                = 1'b1;
    return r;
  endfunction

  function automatic step_row_t sample_step(logic [NUM_LEVELS-1:0] lv,
                                            logic [TIME_W-1:0] t,
                                            bit typed = 1'b0,
                                            report_t want = '0);
    step_row_t s;
    s          = '0;
    s.levels   = lv;
    s.now_ms   = t;
    s.typed    = typed;
    s.want     = want;
    return s;
  endfunction

  function automatic step_row_t cfg_step(cfg_t c);
    step_row_t s;
    s          = '0;
    s.load_cfg = 1'b1;
    s.cfg      = c;
    return s;
  endfunction

  function automatic cfg_t pick_cfg(int phase);
    cfg_t c;
    case (phase)
      0: c = '0;
      1: c = '1;
      2: c = CFG_RESET;
      default: begin
        c.ignore_ms      = CFG_W'($urandom_range(0, 120));
        c.multi_click_ms = CFG_W'($urandom_range(60, 400));
        c.hold_min_ms    = CFG_W'($urandom_range(0, 2500));
        c.hold_repeat_ms = CFG_W'($urandom_range(0, 1500));
        c.hold_max_ms    = ($urandom_range(0, 3) == 0) ? '1 :
                           CFG_W'($urandom_range(1500, 20000));
      end
    endcase
    return c;
  endfunction

  function automatic void compare_field(string name, int unsigned want,
                                        int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one sample beat; the sender runs in bursts with random gaps
  task automatic send_sample(logic [NUM_LEVELS-1:0] lv, logic [TIME_W-1:0] t,
                             bit typed = 1'b0, report_t want = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    smp.valid  <= 1'b1;
    smp.levels <= lv;
    smp.now_ms <= t;
    do @(posedge clk); while (!smp.ready);
    detect_events(lv, t);
    if (typed) pending_reports = {pending_reports, want};
    else pending_reports = {pending_reports, sample_hits};
    burst_left--;
    phase_items++;
  endtask

  // Stop offering and let every expected report drain
  task automatic wait_idle();
    smp.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    logic [CFG_W-1:0] vals [5];
    cfg_reg_t idx [5];
    vals = '{c.ignore_ms, c.multi_click_ms, c.hold_min_ms, c.hold_repeat_ms,
             c.hold_max_ms};
    idx  = '{REG_IGNORE, REG_MULTI_CLICK, REG_HOLD_MIN, REG_HOLD_REPEAT, REG_HOLD_MAX};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // unmapped index must leave every register alone
    cfg_index <= REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2));
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_cfg = c;
    @(posedge clk);
  endtask

  // Well-formed multi-click sequence on a random set of buttons
  task automatic run_click_train();
    logic [NUM_LEVELS-1:0] mask;
    int n;
    mask = NUM_LEVELS'($urandom_range(1, 31));
    n    = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      now_t  += TIME_W'(model_cfg.ignore_ms) + $urandom_range(0, 40);
      cur_lv |= mask;
      send_sample(cur_lv, now_t);
      now_t  += $urandom_range(1, 60);
      cur_lv &= ~mask;
      send_sample(cur_lv, now_t);
    end
    now_t += TIME_W'(model_cfg.multi_click_ms) + $urandom_range(1, 200);
    send_sample(cur_lv, now_t);
  endtask

  // Long press sampled several times, then released and left quiet
  task automatic run_hold();
    logic [NUM_LEVELS-1:0] mask;
    int span, steps;
    mask  = NUM_LEVELS'($urandom_range(1, 31));
    span  = 300;
    if (int'(model_cfg.hold_min_ms) > span) span = model_cfg.hold_min_ms;
    if (int'(model_cfg.hold_repeat_ms) > span) span = model_cfg.hold_repeat_ms;
    steps = $urandom_range(2, 6);
    now_t  += TIME_W'(model_cfg.ignore_ms) + $urandom_range(0, 30);
    cur_lv |= mask;
    send_sample(cur_lv, now_t);
    for (int i = 0; i < steps; i++) begin
      now_t += $urandom_range(span / 4, span + 300);
      send_sample(cur_lv, now_t);
    end
    now_t  += $urandom_range(1, 100);
    cur_lv &= ~mask;
    send_sample(cur_lv, now_t);
    now_t += TIME_W'(model_cfg.multi_click_ms) + $urandom_range(1, 200);
    send_sample(cur_lv, now_t);
  endtask

  // Random levels at random spacing, including large time jumps
  task automatic run_noise();
    int n, pick;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      cur_lv = NUM_LEVELS'($urandom_range(0, 31));
      pick   = $urandom_range(0, 9);
      if (pick < 5) now_t += $urandom_range(0, 40);
      else if (pick < 9) now_t += $urandom_range(0, 3000);
      else now_t += $urandom;
      send_sample(cur_lv, now_t);
    end
  endtask

  // Report monitor and checker
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && rpt.valid && rpt.ready) begin
      got.button              = rpt.button;
      got.res.edge_seen       = rpt.edge_seen;
      got.res.edge_is_release = rpt.edge_is_release;
      got.res.clicks_ready    = rpt.clicks_ready;
      got.res.clicks          = rpt.clicks;
      got.res.hold_seen       = rpt.hold_seen;
      got.res.hold_seconds    = rpt.hold_seconds;
      got.last                = rpt.last;
      if (pending_reports.size() == 0) begin
        $error("unexpected report beat for button %0d", got.button);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("button", want.button, got.button);
        compare_field("edge_seen", want.res.edge_seen, got.res.edge_seen);
        compare_field("edge_is_release", want.res.edge_is_release,
                      got.res.edge_is_release);
        compare_field("clicks_ready", want.res.clicks_ready, got.res.clicks_ready);
        compare_field("clicks", want.res.clicks, got.res.clicks);
        compare_field("hold_seen", want.res.hold_seen, got.res.hold_seen);
        compare_field("hold_seconds", want.res.hold_seconds, got.res.hold_seconds);
        compare_field("last", want.last, got.last);
      end
    end
  end

  // Report receiver: stall pattern changes per window, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int win_left, tick;
    mode     = RX_OPEN;
    win_left = 0;
    tick     = 0;
    rpt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_req) begin
        rpt.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (win_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          win_left = $urandom_range(16, 96);
        end
        win_left--;
        case (mode)
          RX_OPEN:   rpt.ready <= 1'b1;
          RX_COIN:   rpt.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rpt.ready <= (tick % 4 == 0);
          default:   rpt.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (rpt.valid && rpt.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("button_click_hold_detector test failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    step_row_t row;
    cfg_t ext_cfg;
    int pick;
    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_IGNORE;
    cfg_data   <= '0;
    smp.valid  <= 1'b0;
    smp.levels <= '0;
    smp.now_ms <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    clear_lanes();

    // Directed table: reset defaults first, then extreme registers
    ext_cfg = '{ignore_ms: '0, multi_click_ms: '1, hold_min_ms: '0,
                hold_repeat_ms: '0, hold_max_ms: '1};
    add_row(sample_step(5'b00000, 32'd1000));
    add_row(sample_step(5'b00001, 32'd1000, 1'b1,
            lone_report(1, 1, 0, 0, 0, 0, 0)));
    add_row(sample_step(5'b00000, 32'd1100, 1'b1,
            lone_report(1, 1, 1, 0, 0, 0, 0)));
    // press inside the ignore time
    add_row(sample_step(5'b00001, 32'd1120));
    add_row(sample_step(5'b00000, 32'd1400, 1'b1,
            lone_report(1, 0, 0, 1, 1, 0, 0)));
    add_row(sample_step(5'b11111, 32'd2000));
    add_row(sample_step(5'b11111, 32'd3500));
    add_row(sample_step(5'b11111, 32'd4000));
    add_row(sample_step(5'b11111, 32'd4600));
    add_row(sample_step(5'b00000, 32'd5000));
    // hold happened, so the quiet timeout reports nothing
    add_row(sample_step(5'b00000, 32'd5300));
    add_row(cfg_step(ext_cfg));
    add_row(sample_step(5'b10000, 32'd10000, 1'b1,
            lone_report(5, 1, 0, 0, 0, 0, 0)));
    add_row(sample_step(5'b10000, 32'd10001));
    // hold seconds saturate
    add_row(sample_step(5'b10000, 32'd74500, 1'b1,
            lone_report(5, 0, 0, 0, 0, 1, 63)));
    add_row(sample_step(5'b10000, 32'd75535));
    add_row(sample_step(5'b00000, 32'd80000, 1'b1,
            lone_report(5, 1, 1, 0, 0, 0, 0)));
    add_row(sample_step(5'b00000, 32'hFFFF_FFF0));
    // clicks across the time wrap
    add_row(sample_step(5'b00010, 32'hFFFF_FFF8, 1'b1,
            lone_report(2, 1, 0, 0, 0, 0, 0)));
    add_row(sample_step(5'b00000, 32'h0000_0005, 1'b1,
            lone_report(2, 1, 1, 0, 0, 0, 0)));
    add_row(sample_step(5'b00010, 32'h0000_0006));
    add_row(sample_step(5'b00000, 32'h0000_0020));
    add_row(sample_step(5'b00000, 32'h0001_1150));

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.load_cfg) begin
        wait_idle();
        write_config(row.cfg);
      end else begin
        send_sample(row.levels, row.now_ms, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting
    cur_lv = '0;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      write_config(pick_cfg(phase));
      now_t       = $urandom;
      phase_items = 0;
      if (phase == 3) hold_off_req = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) run_click_train();
        else if (pick == 2) run_hold();
        else run_noise();
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_click_hold_detector test passed");
    end else begin
      $display("button_click_hold_detector test failed");
    end
    $finish;
  end

endmodule
